>>> src/moesif_snoop_line_controller_assert.svh
// Assertion macros used by the checker of the snoop line controller.
`ifndef MOESIF_SNOOP_LINE_CONTROLLER_ASSERT_SVH
`define MOESIF_SNOOP_LINE_CONTROLLER_ASSERT_SVH

// Clocked property with an active-low reset that disables the check.
`define MOESIF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define MOESIF_NEVER(label, clk, rst_n, cond, msg) \
	`MOESIF_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

>>> src/moesif_pkg.sv
// Types, codes and defaults shared by the MOESIF snoop line controller.
`timescale 1ns / 1ps
`default_nettype none

package moesif_pkg;

	localparam int NUM_LINES_DEF   = 256;
	localparam int ADDR_BITS_DEF   = 32;
	localparam int MODULE_BITS_DEF = 4;

	localparam logic [3:0] ST_I  = 4'd0;
	localparam logic [3:0] ST_S  = 4'd1;
	localparam logic [3:0] ST_E  = 4'd2;
	localparam logic [3:0] ST_O  = 4'd3;
	localparam logic [3:0] ST_M  = 4'd4;
	localparam logic [3:0] ST_F  = 4'd5;
	localparam logic [3:0] ST_IS = 4'd6;
	localparam logic [3:0] ST_IM = 4'd7;
	localparam logic [3:0] ST_SM = 4'd8;

	localparam logic [2:0] RQ_LOAD  = 3'd0;
	localparam logic [2:0] RQ_STORE = 3'd1;
	localparam logic [2:0] RQ_GETS  = 3'd2;
	localparam logic [2:0] RQ_GETM  = 3'd3;
	localparam logic [2:0] RQ_DATA  = 3'd4;

	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_GETS = 3'd1;
	localparam logic [2:0] ACT_GETM = 3'd2;
	localparam logic [2:0] ACT_PROC = 3'd3;
	localparam logic [2:0] ACT_BUS  = 3'd4;

	typedef struct packed {
		logic [3:0] state;
		logic       owner;
		logic       forward;
	} entry_t;

	typedef struct packed {
		logic [2:0] action;
		logic       assert_shared;
		logic       miss;
		logic       upgrade;
		logic       error;
	} result_t;

	localparam entry_t ENTRY_RESET = '{state: ST_I, owner: 1'b0, forward: 1'b0};

endpackage

`default_nettype wire

>>> src/moesif_snoop_line_controller.sv
// Top level of the MOESIF snoop line controller.
`timescale 1ns / 1ps
`default_nettype none

// After reset the block sweeps the line table to invalid, one line per cycle, and holds
// busy high while it does so. From then on it accepts one request per cycle (start high,
// busy low) and shows the result beat with done once the request has passed the request
// stage register, which also takes the registered read of the line memory, and then the
// output register behind the transition logic. A request to the line that the previous
// request is writing back takes the new entry by forwarding, so requests may follow
// each other in any order. The receiver cannot stall: each result is valid only while
// done is high and must be taken in that cycle.
module moesif_snoop_line_controller #(
	parameter int NUM_LINES   = moesif_pkg::NUM_LINES_DEF,
	parameter int ADDR_BITS   = moesif_pkg::ADDR_BITS_DEF,
	parameter int MODULE_BITS = moesif_pkg::MODULE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [2:0]             req_type,
	input  wire logic [7:0]             line_index,
	input  wire logic [ADDR_BITS-1:0]   line_address,
	input  wire logic [MODULE_BITS-1:0] source_module,
	input  wire logic                   shared_in,
	output logic                        done,
	output logic [2:0]                  action,
	output logic [ADDR_BITS-1:0]        out_address,
	output logic [MODULE_BITS-1:0]      dest_module,
	output logic                        assert_shared,
	output logic                        miss_pulse,
	output logic                        upgrade_pulse,
	output logic                        error
);

	localparam int IW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int XW = (IW > 8) ? IW : 8;

	logic                   clearing_q;
	logic [IW-1:0]          clr_q;
	logic                   accept;
	logic [XW-1:0]          idx_x;
	logic [IW-1:0]          raddr;
	logic                   idx_ok;

	logic                   v_s1;
	logic [2:0]             req_s1;
	logic                   idx_ok_s1;
	logic [ADDR_BITS-1:0]   addr_s1;
	logic [MODULE_BITS-1:0] src_s1;
	logic                   shared_s1;
	logic [IW-1:0]          waddr_s1;
	logic                   fwd_hit_s1;
	moesif_pkg::entry_t     fwd_ent_s1;

	moesif_pkg::entry_t     rdata;
	moesif_pkg::entry_t     cur;
	moesif_pkg::entry_t     nxt;
	moesif_pkg::result_t    res;
	logic                   item_we;
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	moesif_pkg::entry_t     ram_wdata;

	logic                   done_q;
	logic [2:0]             action_q;
	logic [ADDR_BITS-1:0]   out_address_q;
	logic [MODULE_BITS-1:0] dest_module_q;
	logic                   assert_shared_q;
	logic                   miss_q;
	logic                   upgrade_q;
	logic                   error_q;

	assign busy   = clearing_q;
	assign accept = start && !clearing_q;
	assign idx_x  = XW'(line_index);
	assign raddr  = idx_x[IW-1:0];
	assign idx_ok = ({24'd0, line_index} < 32'(NUM_LINES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == IW'(NUM_LINES - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= req_type;
			idx_ok_s1  <= idx_ok;
			addr_s1    <= line_address;
			src_s1     <= source_module;
			shared_s1  <= shared_in;
			waddr_s1   <= raddr;
			fwd_hit_s1 <= item_we && (raddr == waddr_s1);
			fwd_ent_s1 <= nxt;
		end
	end

	moesif_line_ram #(
		.DEPTH(NUM_LINES),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cur = fwd_hit_s1 ? fwd_ent_s1 : rdata;

	moesif_line_logic u_logic (
		.req_type (req_s1),
		.idx_ok   (idx_ok_s1),
		.shared_in(shared_s1),
		.cur      (cur),
		.nxt      (nxt),
		.res      (res)
	);

	assign item_we   = v_s1 && !res.error;
	assign ram_we    = clearing_q || item_we;
	assign ram_waddr = clearing_q ? clr_q : waddr_s1;
	assign ram_wdata = clearing_q ? moesif_pkg::ENTRY_RESET : nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			action_q        <= res.action;
			out_address_q   <= (res.action != moesif_pkg::ACT_NONE) ? addr_s1 : '0;
			dest_module_q   <= (res.action == moesif_pkg::ACT_BUS) ? src_s1 : '0;
			assert_shared_q <= res.assert_shared;
			miss_q          <= res.miss;
			upgrade_q       <= res.upgrade;
			error_q         <= res.error;
		end
	end

	assign done          = done_q;
	assign action        = action_q;
	assign out_address   = out_address_q;
	assign dest_module   = dest_module_q;
	assign assert_shared = assert_shared_q;
	assign miss_pulse    = miss_q;
	assign upgrade_pulse = upgrade_q;
	assign error         = error_q;

endmodule

`default_nettype wire

>>> src/moesif_line_ram.sv
// Line table memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module moesif_line_ram #(
	parameter int DEPTH = moesif_pkg::NUM_LINES_DEF,
	parameter int AW    = 8
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire moesif_pkg::entry_t wdata,
	input  wire logic [AW-1:0]      raddr,
	output moesif_pkg::entry_t      rdata
);

	moesif_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/moesif_line_logic.sv
// Coherence transition logic: next line entry and result for one request.
`timescale 1ns / 1ps
`default_nettype none

module moesif_line_logic (
	input  wire logic [2:0]         req_type,
	input  wire logic               idx_ok,
	input  wire logic               shared_in,
	input  wire moesif_pkg::entry_t cur,
	output moesif_pkg::entry_t      nxt,
	output moesif_pkg::result_t     res
);

	logic [3:0] st;
	logic       is_store;

	always_comb begin
		st = cur.state;
		if (st > moesif_pkg::ST_SM) begin
			st = moesif_pkg::ST_I;
		end
		is_store = (req_type == moesif_pkg::RQ_STORE);
		nxt = cur;
		nxt.state = st;
		res = '0;
		res.action = moesif_pkg::ACT_NONE;
		if (!idx_ok || req_type > moesif_pkg::RQ_DATA) begin
			res.error = 1'b1;
			nxt = cur;
		end else if (req_type == moesif_pkg::RQ_LOAD || is_store) begin
			case (st)
				moesif_pkg::ST_I: begin
					res.action = is_store ? moesif_pkg::ACT_GETM : moesif_pkg::ACT_GETS;
					nxt.state  = is_store ? moesif_pkg::ST_IM : moesif_pkg::ST_IS;
					res.miss   = 1'b1;
				end
				moesif_pkg::ST_S, moesif_pkg::ST_F, moesif_pkg::ST_O: begin
					if (is_store) begin
						if (st == moesif_pkg::ST_O) begin
							nxt.owner = 1'b1;
						end
						res.action = moesif_pkg::ACT_GETM;
						nxt.state  = moesif_pkg::ST_SM;
						res.miss   = 1'b1;
					end else begin
						res.action = moesif_pkg::ACT_PROC;
					end
				end
				moesif_pkg::ST_E: begin
					res.action = moesif_pkg::ACT_PROC;
					if (is_store) begin
						nxt.state   = moesif_pkg::ST_M;
						res.upgrade = 1'b1;
					end
				end
				moesif_pkg::ST_M: begin
					res.action = moesif_pkg::ACT_PROC;
				end
				default: begin
				end
			endcase
		end else begin
			case (st)
				moesif_pkg::ST_S: begin
					if (req_type == moesif_pkg::RQ_GETS) begin
						res.assert_shared = 1'b1;
					end else if (req_type == moesif_pkg::RQ_GETM) begin
						nxt.state = moesif_pkg::ST_I;
					end
				end
				moesif_pkg::ST_E, moesif_pkg::ST_O, moesif_pkg::ST_M, moesif_pkg::ST_F: begin
					if (req_type != moesif_pkg::RQ_DATA) begin
						res.assert_shared = 1'b1;
						res.action = moesif_pkg::ACT_BUS;
						if (req_type == moesif_pkg::RQ_GETM) begin
							nxt.state = moesif_pkg::ST_I;
						end else if (st == moesif_pkg::ST_E) begin
							nxt.state   = moesif_pkg::ST_F;
							nxt.forward = 1'b1;
						end else if (st == moesif_pkg::ST_M) begin
							nxt.state = moesif_pkg::ST_O;
						end
					end
				end
				moesif_pkg::ST_IS: begin
					if (req_type == moesif_pkg::RQ_DATA) begin
						res.action = moesif_pkg::ACT_PROC;
						nxt.state  = shared_in ? moesif_pkg::ST_S : moesif_pkg::ST_E;
					end
				end
				moesif_pkg::ST_IM: begin
					if (req_type == moesif_pkg::RQ_DATA) begin
						res.action = moesif_pkg::ACT_PROC;
						nxt.state  = moesif_pkg::ST_M;
					end
				end
				moesif_pkg::ST_SM: begin
					if (req_type == moesif_pkg::RQ_GETS) begin
						if (cur.forward && !shared_in) begin
							res.action = moesif_pkg::ACT_BUS;
						end
						res.assert_shared = 1'b1;
					end else if (req_type == moesif_pkg::RQ_GETM) begin
						if ((cur.owner || cur.forward) && !shared_in) begin
							res.assert_shared = 1'b1;
							res.action = moesif_pkg::ACT_BUS;
						end
					end else begin
						nxt.owner   = 1'b0;
						nxt.forward = 1'b0;
						res.action  = moesif_pkg::ACT_PROC;
						nxt.state   = moesif_pkg::ST_M;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/moesif_snoop_line_controller_checker.sv
// Port-level checker for the snoop line controller and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "moesif_snoop_line_controller_assert.svh"

module moesif_snoop_line_controller_checker #(
	parameter int ADDR_BITS   = moesif_pkg::ADDR_BITS_DEF,
	parameter int MODULE_BITS = moesif_pkg::MODULE_BITS_DEF
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic                   done,
	input wire logic [2:0]             action,
	input wire logic [ADDR_BITS-1:0]   out_address,
	input wire logic [MODULE_BITS-1:0] dest_module,
	input wire logic                   miss_pulse,
	input wire logic                   upgrade_pulse,
	input wire logic                   error
);

	`MOESIF_ASSERT(a_beat_two_after_accept, clk, arst_n, (start && !busy) |-> ##2 done, "accepted request gave no result beat two cycles later")
	`MOESIF_ASSERT(a_beat_has_request, clk, arst_n, done |-> $past(start && !busy, 2), "result beat without an accepted request")
	`MOESIF_NEVER(a_idle_address, clk, arst_n, done && action == moesif_pkg::ACT_NONE && out_address != '0, "address shown without an action")
	`MOESIF_NEVER(a_dest_only_bus, clk, arst_n, done && action != moesif_pkg::ACT_BUS && dest_module != '0, "destination shown without bus data")
	`MOESIF_NEVER(a_error_quiet, clk, arst_n, done && error && (action != moesif_pkg::ACT_NONE || miss_pulse || upgrade_pulse), "rejected request produced an action or pulse")

endmodule

bind moesif_snoop_line_controller moesif_snoop_line_controller_checker #(
	.ADDR_BITS  (ADDR_BITS),
	.MODULE_BITS(MODULE_BITS)
) u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.action       (action),
	.out_address  (out_address),
	.dest_module  (dest_module),
	.miss_pulse   (miss_pulse),
	.upgrade_pulse(upgrade_pulse),
	.error        (error)
);

`default_nettype wire
